/* src/scaled_sample_rms_peak_window_defines.svh */
// Assertion macros for the windowed RMS and peak meter checker.
// Depends on nothing; the checker includes it by bare file name.
`ifndef SCALED_SAMPLE_RMS_PEAK_WINDOW_DEFINES_SVH
`define SCALED_SAMPLE_RMS_PEAK_WINDOW_DEFINES_SVH

// Check a property outside reset.
`define SRPW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SRPW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/srpw_pkg.sv */
// Shared types, constants and helpers for the windowed RMS and peak meter.
// No dependencies.
package srpw_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF   = 12;
    localparam int SAMPLE_W        = 12;
    localparam int TS_W            = 32;
    localparam int LEVEL_W         = 24;
    localparam int PEAK_W          = 23;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 32;
    localparam int US_PER_MS       = 1000;
    localparam int SPAN_W          = 26;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS = 2'd3;

    localparam logic KIND_INSTANT = 1'b0;
    localparam logic KIND_WINDOW  = 1'b1;

    typedef struct packed {
        logic [31:0]         gain;
        logic signed [23:0]  offset;
        logic [PEAK_W-1:0]   cutoff;
        logic [15:0]         window_ms;
    } t_cfg;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] value;
        logic [TS_W-1:0]           ts;
    } t_item;

    typedef struct packed {
        logic                      kind;
        logic signed [LEVEL_W-1:0] level;
        logic [PEAK_W-1:0]         peak;
    } t_result;

    function automatic logic [PEAK_W-1:0] mag23(input logic signed [LEVEL_W-1:0] v);
        logic [LEVEL_W-1:0] m;
        m = v[LEVEL_W-1] ? LEVEL_W'(-v) : LEVEL_W'(v);
        if (m[LEVEL_W-1]) mag23 = {PEAK_W{1'b1}};
        else mag23 = m[PEAK_W-1:0];
    endfunction

endpackage

/* src/srpw_front.sv */
// Front end: accepts input words; scales and offsets (zero gain passes the raw sample), clamps, cuts off.
// Depends on srpw_pkg.
module srpw_front #(
    parameter int SAMPLE_BITS = srpw_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = srpw_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  srpw_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [srpw_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic [srpw_pkg::TS_W-1:0]         i_ts,
    output logic                              o_push,
    output srpw_pkg::t_item                   o_item,
    input  logic                              i_q_ready
);
    import srpw_pkg::*;

    localparam int PW = SAMPLE_BITS + 32;
    localparam int VW = SAMPLE_BITS + 34;
    localparam int SH = 16 - FRAC_BITS;

    logic                   r_vld;
    logic [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic                   r_raw;
    logic [TS_W-1:0]        r_ts;

    logic [SAMPLE_BITS-1:0] w_smp;
    logic signed [VW-1:0]   w_v;
    logic signed [LEVEL_W-1:0] w_c;
    logic [LEVEL_W-1:0]     w_mag;

    assign o_ready = !r_vld || i_q_ready;
    assign w_smp   = SAMPLE_BITS'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_vld <= 1'b1;
        end else if (i_q_ready) begin
            r_vld <= 1'b0;
        end
    end

    // Register the gain product before the offset and clamp.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_prod <= PW'(w_smp) * PW'(i_cfg.gain);
            r_smp  <= w_smp;
            r_raw  <= (i_cfg.gain == 32'd0);
            r_ts   <= i_ts;
        end
    end

    always_comb begin
        if (r_raw) begin
            w_v = $signed(VW'(r_smp) << FRAC_BITS);
        end else begin
            w_v = $signed(VW'(r_prod >> SH)) - VW'(i_cfg.offset);
        end
        if (w_v > VW'(signed'(2**(LEVEL_W-1) - 1))) begin
            w_c = {1'b0, {(LEVEL_W-1){1'b1}}};
        end else if (w_v < -VW'(signed'(2**(LEVEL_W-1)))) begin
            w_c = {1'b1, {(LEVEL_W-1){1'b0}}};
        end else begin
            w_c = w_v[LEVEL_W-1:0];
        end
        w_mag = w_c[LEVEL_W-1] ? LEVEL_W'(-w_c) : LEVEL_W'(w_c);
        o_item.ts    = r_ts;
        o_item.value = (w_mag < {1'b0, i_cfg.cutoff}) ? '0 : w_c;
    end

    assign o_push = r_vld;

endmodule

/* src/srpw_queue.sv */
// Two-entry queue between the front end and the window engine.
// Depends on srpw_pkg.
module srpw_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  srpw_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output srpw_pkg::t_item o_item,
    input  logic            i_pop
);
    import srpw_pkg::*;

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_wr;
    logic       w_rd;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_wr    = i_push && o_ready;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_item;
    end

endmodule

/* src/srpw_back.sv */
// Window engine: zero-window pass-through; energy accumulation, peak, divide and square root, output register.
// Depends on srpw_pkg.
module srpw_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [15:0]             i_window_ms,
    input  logic                    i_valid,
    input  srpw_pkg::t_item         i_item,
    output logic                    o_pop,
    output logic                    o_res_valid,
    output srpw_pkg::t_result       o_res,
    input  logic                    i_res_ready
);
    import srpw_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MLO  = 8'b0000_0010,
        ST_MHI  = 8'b0000_0100,
        ST_TERM = 8'b0000_1000,
        ST_SUM  = 8'b0001_0000,
        ST_DIV  = 8'b0010_0000,
        ST_SQRT = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    t_state                    r_st;
    logic                      r_active;
    logic [TS_W-1:0]           r_wstart;
    logic [TS_W-1:0]           r_last_t;
    logic signed [LEVEL_W-1:0] r_last_v;
    logic [63:0]               r_sum;
    logic [PEAK_W-1:0]         r_peak;

    t_item                     r_cur;
    logic [47:0]               r_sq4;
    logic [31:0]               r_dt;
    logic [55:0]               r_plo;
    logic [55:0]               r_phi;
    logic [63:0]               r_term;
    logic [31:0]               r_div;
    logic [31:0]               r_rem;
    logic [63:0]               r_quo;
    logic [33:0]               r_srem;
    logic [31:0]               r_root;
    logic [5:0]                r_cnt;
    logic                      r_out_vld;
    t_result                   r_out;

    logic [SPAN_W-1:0]         w_span;
    logic signed [LEVEL_W:0]   w_s;
    logic signed [49:0]        w_sq;
    logic [79:0]               w_full;
    logic [64:0]               w_acc;
    logic [31:0]               w_elapsed;
    logic [32:0]               w_dsh;
    logic [33:0]               w_st;
    logic [33:0]               w_trial;

    assign w_span    = SPAN_W'(i_window_ms) * SPAN_W'(US_PER_MS);
    assign w_s       = (LEVEL_W+1)'(i_item.value) + (LEVEL_W+1)'(r_last_v);
    // Wide enough for the square of the most negative midpoint sum.
    assign w_sq      = 50'(w_s) * 50'(w_s);
    assign w_full    = {r_phi, 24'd0} + 80'(r_plo);
    assign w_acc     = {1'b0, r_sum} + {1'b0, r_term};
    assign w_elapsed = r_cur.ts - r_wstart;
    assign w_dsh     = {r_rem, r_quo[63]};
    assign w_st      = {r_srem[31:0], r_quo[63:62]};
    assign w_trial   = {r_root, 2'b01};

    assign o_pop       = (r_st == ST_IDLE) && i_valid;
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st      <= ST_IDLE;
            r_active  <= 1'b0;
            r_wstart  <= '0;
            r_last_t  <= '0;
            r_last_v  <= '0;
            r_sum     <= '0;
            r_peak    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_cur <= i_item;
                        if (w_span == '0) begin
                            // Pass the value straight through.
                            r_out.kind  <= KIND_INSTANT;
                            r_out.level <= i_item.value;
                            r_out.peak  <= '0;
                            r_out_vld   <= 1'b1;
                            r_st        <= ST_OUT;
                        end else if (!r_active || (i_item.ts < r_last_t)) begin
                            r_active <= 1'b1;
                            r_wstart <= i_item.ts;
                            r_sum    <= '0;
                            r_peak   <= mag23(i_item.value);
                            r_last_v <= i_item.value;
                            r_last_t <= i_item.ts;
                        end else begin
                            r_sq4 <= w_sq[49:2];
                            r_dt  <= i_item.ts - r_last_t;
                            r_st  <= ST_MLO;
                        end
                    end
                end
                ST_MLO: begin
                    r_plo <= 56'(r_sq4[23:0]) * 56'(r_dt);
                    r_st  <= ST_MHI;
                end
                ST_MHI: begin
                    r_phi <= 56'(r_sq4[47:24]) * 56'(r_dt);
                    r_st  <= ST_TERM;
                end
                ST_TERM: begin
                    r_term <= (w_full[79:64] != '0) ? '1 : w_full[63:0];
                    r_st   <= ST_SUM;
                end
                ST_SUM: begin
                    r_sum <= w_acc[64] ? '1 : w_acc[63:0];
                    if (mag23(r_cur.value) > r_peak) r_peak <= mag23(r_cur.value);
                    if (w_elapsed >= 32'(w_span)) begin
                        r_div <= w_elapsed;
                        r_rem <= '0;
                        r_quo <= w_acc[64] ? '1 : w_acc[63:0];
                        r_cnt <= '0;
                        r_st  <= ST_DIV;
                    end else begin
                        r_last_v <= r_cur.value;
                        r_last_t <= r_cur.ts;
                        r_st     <= ST_IDLE;
                    end
                end
                ST_DIV: begin
                    // One quotient bit per cycle, restoring.
                    if (w_dsh >= {1'b0, r_div}) begin
                        r_rem <= 32'(w_dsh - {1'b0, r_div});
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= w_dsh[31:0];
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_srem <= '0;
                        r_root <= '0;
                        r_st   <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    // One root bit per cycle from two radicand bits.
                    r_quo <= {r_quo[61:0], 2'b00};
                    if (w_st >= w_trial) begin
                        r_srem <= w_st - w_trial;
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_srem <= w_st;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt[4:0] == 5'd31) r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_vld) begin
                        r_out.kind  <= KIND_WINDOW;
                        r_out.level <= (r_root > 32'(2**(LEVEL_W-1) - 1))
                            ? {1'b0, {(LEVEL_W-1){1'b1}}} : r_root[LEVEL_W-1:0];
                        r_out.peak  <= r_peak;
                        r_out_vld   <= 1'b1;
                        r_active    <= 1'b0;
                    end else if (i_res_ready) begin
                        r_out_vld <= 1'b0;
                        r_st      <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

/* src/scaled_sample_rms_peak_window.sv */
// Top level of the windowed RMS and peak meter: config registers and channel wiring.
// Depends on srpw_pkg, srpw_front, srpw_queue, srpw_back.
//
// Usage:
//  - Input stream s_axis: one word per converter sample, raw reading plus
//    microsecond timestamp. Output stream m_axis: one result word, kind in
//    tuser (0 instant value, 1 window RMS and peak).
//  - Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
//    (0 gain, 1 offset, 2 cutoff, 3 window_ms). Write only while idle.
//  - The front end takes a word per cycle, while the queue has room, into
//    a one-register scaler and a two-entry queue; the window engine takes
//    one queued word at a time and none new until it is done with the last.
//  - With a zero window a result passes the scaler register, a queue entry
//    and the output register. A window start is handled in the idle state; a
//    mid-window sample takes two 24x32 partial products, saturating term and
//    sum; a window end adds the restoring divide and the square root, both
//    one-bit-per-cycle loops. The queue lets the input keep accepting while
//    the engine works.
//  - Stall: a result is held in the output register until m_axis_tready;
//    the engine waits, the queue fills, then s_axis_tready drops.
//  - Reset (i_rst_n low, synchronous): config registers clear to zero, no
//    window is open, queue and output are empty.
module scaled_sample_rms_peak_window #(
    parameter int SAMPLE_BITS = srpw_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = srpw_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [srpw_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [srpw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [47:0]                         s_axis_tdata,  // sample[11:0], timestamp_us[43:12]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [47:0]                         m_axis_tdata,  // level[23:0], peak[46:24]
    output logic                                m_axis_tuser   // kind
);
    import srpw_pkg::*;

    t_cfg    r_cfg;
    t_item   w_f_item;
    t_item   w_q_item;
    t_result w_res;
    logic    w_push;
    logic    w_q_ready;
    logic    w_q_valid;
    logic    w_pop;

    // Hold the configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GAIN:      r_cfg.gain      <= i_cfg_data;
                REG_OFFSET:    r_cfg.offset    <= i_cfg_data[23:0];
                REG_CUTOFF:    r_cfg.cutoff    <= i_cfg_data[PEAK_W-1:0];
                REG_WINDOW_MS: r_cfg.window_ms <= i_cfg_data[15:0];
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    srpw_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_sample  (s_axis_tdata[SAMPLE_W-1:0]),
        .i_ts      (s_axis_tdata[SAMPLE_W+TS_W-1:SAMPLE_W]),
        .o_push    (w_push),
        .o_item    (w_f_item),
        .i_q_ready (w_q_ready)
    );

    srpw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    srpw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_window_ms (r_cfg.window_ms),
        .i_valid     (w_q_valid),
        .i_item      (w_q_item),
        .o_pop       (w_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    // Pack the result word, zero fill to whole bytes.
    assign m_axis_tdata = {1'b0, w_res.peak, w_res.level};
    assign m_axis_tuser = w_res.kind;

endmodule

/* src/srpw_checker.sv */
// Port-level checker for the windowed RMS and peak meter, bound to the top level.
// Depends on scaled_sample_rms_peak_window_defines.svh.
`include "scaled_sample_rms_peak_window_defines.svh"
module srpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    // Empty output right after reset.
    `SRPW_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !m_axis_tvalid, "output valid after reset")
    // Stalled result holds.
    `SRPW_ASSERT(a_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
    // Instant results carry no peak.
    `SRPW_ASSERT(a_inst_peak, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[46:24] == 23'd0, "instant result with peak")
    // Window RMS is never negative.
    `SRPW_ASSERT(a_rms_pos, m_axis_tvalid && m_axis_tuser |-> !m_axis_tdata[23], "negative window level")
endmodule

bind scaled_sample_rms_peak_window srpw_checker u_srpw_checker (.*);
